// ----- rtl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg
// shared types and constants of the auto-exposure step block
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned DivSteps = 32;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam logic [15:0] RatioSat     = 16'hffff;
  localparam logic [9:0]  ExposureInit = 10'h080;
  localparam logic [9:0]  GainInit     = 10'h010;

  localparam logic [7:0]  TargetLevelRst    = 8'd65;
  localparam logic [7:0]  RaiseThresholdRst = 8'd20;
  localparam logic [7:0]  LowerThresholdRst = 8'd12;
  localparam logic [9:0]  ExposureMaxRst    = 10'h3ff;
  localparam logic [9:0]  ExposureMinRst    = 10'd1;
  localparam logic [9:0]  GainMaxRst        = 10'h3ff;
  localparam logic [9:0]  GainMinRst        = 10'd16;

  typedef enum logic [2:0] {
    REG_TARGET_LEVEL    = 3'd0,
    REG_RAISE_THRESHOLD = 3'd1,
    REG_LOWER_THRESHOLD = 3'd2,
    REG_EXPOSURE_MAX    = 3'd3,
    REG_EXPOSURE_MIN    = 3'd4,
    REG_GAIN_MAX        = 3'd5,
    REG_GAIN_MIN        = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DECIDE,
    ST_SCALE,
    ST_APPLY
  } state_e;

  typedef enum logic [1:0] {
    MOVE_NONE,
    MOVE_EXPOSURE,
    MOVE_GAIN
  } move_e;

  typedef struct packed {
    logic [7:0] target_level;
    logic [7:0] raise_threshold;
    logic [7:0] lower_threshold;
    logic [9:0] exposure_max;
    logic [9:0] exposure_min;
    logic [9:0] gain_max;
    logic [9:0] gain_min;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic decide;
    logic scale;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } stat_t;

endpackage

// ----- rtl/aes_ctrl.sv -----
// ----------------------------------------------------------------------------
// aes_ctrl
// sequencer: accept, divide, decide, scale, apply
// ----------------------------------------------------------------------------
module aes_ctrl
  import aes_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_APPLY;
      end
      ST_APPLY: begin
        if (!stat_i.out_blocked) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/aes_datapath.sv -----
// ----------------------------------------------------------------------------
// aes_datapath
// ratio divider, step arithmetic, exposure and gain state, result register
// ----------------------------------------------------------------------------
module aes_datapath
  import aes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [23:0] pixel_count_i,
  input  logic [31:0] luma_sum_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  exposure_o,
  output logic [9:0]  gain_o,
  output logic        updated_o
);

  // divider
  logic [31:0] quo_q;
  logic [27:0] rem_q;
  logic [27:0] dvs_q;
  logic [28:0] trial;
  logic [28:0] diff;
  logic        ge;
  logic [31:0] num;

  // decision and step
  logic [15:0] ratio;
  logic [15:0] ratio_q;
  move_e       move_q, move_d;
  logic        up_q, up_d;
  logic        upd_q, upd_d;
  logic [9:0]  val_q, val_d;
  logic [9:0]  lim_q, lim_d;
  logic [25:0] prod;
  logic [21:0] scaled_q;

  logic [21:0] v22;
  logic [21:0] d_up, d_dn, step;
  logic [22:0] sum_up;
  logic [22:0] lim_plus;
  logic [21:0] diff_dn;
  logic [9:0]  new_val;

  // state and result
  logic [9:0]  exposure_q;
  logic [9:0]  gain_q;
  logic        out_valid_q;
  logic [9:0]  out_exposure_q;
  logic [9:0]  out_gain_q;
  logic        out_updated_q;

  assign num   = {8'd0, pixel_count_i} * {24'd0, cfg_i.target_level};
  assign trial = {rem_q, quo_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q <= num;
      rem_q <= '0;
      dvs_q <= luma_sum_i[31:4];
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[30:0], ge};
      rem_q <= ge ? diff[27:0] : trial[27:0];
    end
  end

  assign ratio = (dvs_q == '0 || (|quo_q[31:16])) ? RatioSat : quo_q[15:0];

  always_comb begin
    move_d = MOVE_NONE;
    up_d   = 1'b0;
    upd_d  = 1'b0;
    val_d  = exposure_q;
    lim_d  = cfg_i.exposure_max;
    if (ratio > {8'd0, cfg_i.raise_threshold}) begin
      upd_d = 1'b1;
      up_d  = 1'b1;
      if (exposure_q < cfg_i.exposure_max) begin
        move_d = MOVE_EXPOSURE;
        val_d  = exposure_q;
        lim_d  = cfg_i.exposure_max;
      end else if (gain_q < cfg_i.gain_max) begin
        move_d = MOVE_GAIN;
        val_d  = gain_q;
        lim_d  = cfg_i.gain_max;
      end
    end else if (ratio < {8'd0, cfg_i.lower_threshold}) begin
      upd_d = 1'b1;
      if (gain_q > cfg_i.gain_min) begin
        move_d = MOVE_GAIN;
        val_d  = gain_q;
        lim_d  = cfg_i.gain_min;
      end else if (exposure_q > cfg_i.exposure_min) begin
        move_d = MOVE_EXPOSURE;
        val_d  = exposure_q;
        lim_d  = cfg_i.exposure_min;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      ratio_q <= ratio;
      move_q  <= move_d;
      up_q    <= up_d;
      upd_q   <= upd_d;
      val_q   <= val_d;
      lim_q   <= lim_d;
    end
  end

  assign prod = {16'd0, val_q} * {10'd0, ratio_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      scaled_q <= prod[25:4];
    end
  end

  // half the excess, at least one, clamped to the limit
  assign v22      = {12'd0, val_q};
  assign d_up     = (scaled_q > v22) ? ((scaled_q - v22) >> 1) : '0;
  assign d_dn     = (scaled_q < v22) ? ((v22 - scaled_q) >> 1) : '0;
  assign step     = up_q ? ((d_up == '0) ? 22'd1 : d_up) : ((d_dn == '0) ? 22'd1 : d_dn);
  assign sum_up   = {1'b0, v22} + {1'b0, step};
  assign lim_plus = {13'd0, lim_q} + {1'b0, step};
  assign diff_dn  = v22 - step;

  always_comb begin
    if (up_q) begin
      new_val = (sum_up > {13'd0, lim_q}) ? lim_q : sum_up[9:0];
    end else begin
      new_val = ({1'b0, v22} < lim_plus) ? lim_q : diff_dn[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exposure_q  <= ExposureInit;
      gain_q      <= GainInit;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        out_valid_q <= 1'b1;
        if (move_q == MOVE_EXPOSURE) begin
          exposure_q <= new_val;
        end
        if (move_q == MOVE_GAIN) begin
          gain_q <= new_val;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      out_exposure_q <= (move_q == MOVE_EXPOSURE) ? new_val : exposure_q;
      out_gain_q     <= (move_q == MOVE_GAIN) ? new_val : gain_q;
      out_updated_q  <= upd_q;
    end
  end

  assign stat_o.out_blocked = out_valid_q & out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign exposure_o         = out_exposure_q;
  assign gain_o             = out_gain_q;
  assign updated_o          = out_updated_q;

endmodule

// ----- rtl/auto_exposure_step.sv -----
// ----------------------------------------------------------------------------
// auto_exposure_step
// per-frame auto-exposure step with exposure-first raise, gain-first lower
// ----------------------------------------------------------------------------
// One statistics beat (pixel count, luma sum) gives one result beat with the
// new exposure and gain and an updated flag. From accept to result,
// count*target is formed and registered in the accept cycle, then the
// one-bit-per-cycle restoring divider yields the correction ratio, then the
// decide, scale and apply states pick the value to move, multiply it by the
// ratio and apply the clamped step. The next beat is accepted in the cycle
// after the step is applied, so a new beat is not taken before the last is
// through; a result held in the output register only stalls the apply cycle
// of the following item. The user must write registers through the cfg
// port only while no item is in flight; the block itself does not enforce it.
module auto_exposure_step
  import aes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] pixel_count_i,
  input  logic [31:0] luma_sum_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  exposure_o,
  output logic [9:0]  gain_o,
  output logic        updated_o
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_level    <= TargetLevelRst;
      cfg_q.raise_threshold <= RaiseThresholdRst;
      cfg_q.lower_threshold <= LowerThresholdRst;
      cfg_q.exposure_max    <= ExposureMaxRst;
      cfg_q.exposure_min    <= ExposureMinRst;
      cfg_q.gain_max        <= GainMaxRst;
      cfg_q.gain_min        <= GainMinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET_LEVEL:    cfg_q.target_level    <= cfg_data_i[7:0];
        REG_RAISE_THRESHOLD: cfg_q.raise_threshold <= cfg_data_i[7:0];
        REG_LOWER_THRESHOLD: cfg_q.lower_threshold <= cfg_data_i[7:0];
        REG_EXPOSURE_MAX:    cfg_q.exposure_max    <= cfg_data_i;
        REG_EXPOSURE_MIN:    cfg_q.exposure_min    <= cfg_data_i;
        REG_GAIN_MAX:        cfg_q.gain_max        <= cfg_data_i;
        REG_GAIN_MIN:        cfg_q.gain_min        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  aes_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pixel_count_i (pixel_count_i),
    .luma_sum_i    (luma_sum_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .exposure_o    (exposure_o),
    .gain_o        (gain_o),
    .updated_o     (updated_o)
  );

endmodule
